/* rtl/idta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idta_pkg
// shared widths, character codes and the digit cell control type
// ----------------------------------------------------------------------------
package idta_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);
  localparam int unsigned RemWidth   = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0]  ChZero    = 6'd48;
  localparam logic [CharWidth-1:0]  ChMinus   = 6'd45;
  localparam logic [DigitWidth-1:0] DigitFive = 4'd5;
  localparam logic [DigitWidth-1:0] DigitAdj  = 4'd3;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/idta_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idta_in_if
// input channel: one signed integer per transfer
// ----------------------------------------------------------------------------
interface idta_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [idta_pkg::ValueWidth-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

/* rtl/idta_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idta_out_if
// output channel: one ascii character per transfer
// ----------------------------------------------------------------------------
interface idta_out_if;
  logic                             valid;
  logic                             ready;
  logic [idta_pkg::CharWidth-1:0]   text_char;
  logic                             final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink   (input valid, input text_char, input final_char, output ready);
endinterface
`default_nettype wire

/* rtl/idta_bcd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idta_bcd_cell
// one decimal digit of the shift-and-add-3 chain, also shifts digits upward
// ----------------------------------------------------------------------------
module idta_bcd_cell (
  input  wire logic                               clk_i,
  input  wire idta_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic                               bit_i,
  input  wire logic [idta_pkg::DigitWidth-1:0]    digit_i,
  output logic                                    bit_o,
  output logic [idta_pkg::DigitWidth-1:0]         digit_o
);

  logic [idta_pkg::DigitWidth-1:0] digit_q;
  logic [idta_pkg::DigitWidth-1:0] corr;

  always_comb begin
    corr = (digit_q >= idta_pkg::DigitFive) ? digit_q + idta_pkg::DigitAdj : digit_q;
  end

  assign bit_o   = corr[idta_pkg::DigitWidth-1];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      digit_q <= '0;
    end else if (ctrl_i.dabble) begin
      digit_q <= {corr[idta_pkg::DigitWidth-2:0], bit_i};
    end else if (ctrl_i.move) begin
      digit_q <= digit_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, most significant digit first
// ----------------------------------------------------------------------------
// One integer is taken per conversion. Its magnitude is shifted one bit per
// cycle into a row of ten BCD digit cells (shift and add 3). Leading zero
// digits are then shifted out of the top cell, one per cycle (up to nine),
// and the text leaves one character per cycle, when the receiver is ready,
// from an output register: an optional '-' and then the digits, the last one
// flagged with final_char. A new integer is accepted while the last
// character still waits for transfer.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  idta_in_if.sink     in_i,
  idta_out_if.source  out_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  localparam int unsigned ND = idta_pkg::NumDigits;
  localparam logic [idta_pkg::CntWidth-1:0] ConvLast = idta_pkg::CntWidth'(idta_pkg::ValueWidth - 1);
  localparam logic [idta_pkg::RemWidth-1:0] RemFull  = idta_pkg::RemWidth'(ND);
  localparam logic [idta_pkg::RemWidth-1:0] RemOne   = idta_pkg::RemWidth'(1);

  state_e                            state_q;
  logic [idta_pkg::ValueWidth-1:0]   mag_q;
  logic                              neg_q;
  logic [idta_pkg::CntWidth-1:0]     cnt_q;
  logic [idta_pkg::RemWidth-1:0]     remain_q;
  logic                              out_valid_q;
  logic [idta_pkg::CharWidth-1:0]    out_char_q;
  logic                              out_final_q;

  idta_pkg::cell_ctrl_t              ctrl;
  logic                              in_xfer;
  logic                              out_free;
  logic                              char_load;
  logic                              skip_zero;
  logic [ND-1:0]                     carry;
  logic [idta_pkg::DigitWidth-1:0]   dig_in  [ND];
  logic [idta_pkg::DigitWidth-1:0]   dig_out [ND];
  logic [idta_pkg::DigitWidth-1:0]   top_digit;

  assign in_i.ready       = (state_q == StIdle);
  assign in_xfer          = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.text_char  = out_char_q;
  assign out_o.final_char = out_final_q;
  assign out_free         = !out_valid_q || out_o.ready;
  assign char_load        = out_free && ((state_q == StSign) || (state_q == StEmit));

  assign top_digit = dig_out[ND-1];
  assign skip_zero = (top_digit == '0) && (remain_q > RemOne);

  always_comb begin
    ctrl.clear  = in_xfer;
    ctrl.dabble = (state_q == StConv);
    ctrl.move   = ((state_q == StSkip) && skip_zero) || ((state_q == StEmit) && out_free);
  end

  // digit row, bits enter at cell 0 and digits move toward the top cell
  assign carry[0]  = mag_q[idta_pkg::ValueWidth-1];
  assign dig_in[0] = '0;

  for (genvar i = 0; i < ND; i++) begin : g_cell
    logic cell_bit;

    idta_bcd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   (carry[i]),
      .digit_i (dig_in[i]),
      .bit_o   (cell_bit),
      .digit_o (dig_out[i])
    );

    if (i < ND - 1) begin : g_link
      assign carry[i+1]  = cell_bit;
      assign dig_in[i+1] = dig_out[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_final_q <= 1'b0;
    end else begin
      if (char_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            neg_q    <= in_i.value[idta_pkg::ValueWidth-1];
            mag_q    <= in_i.value[idta_pkg::ValueWidth-1] ? (~in_i.value + 1'b1)
                                                            : in_i.value;
            cnt_q    <= '0;
            remain_q <= RemFull;
            state_q  <= StConv;
          end
        end
        StConv: begin
          mag_q <= {mag_q[idta_pkg::ValueWidth-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == ConvLast) begin
            state_q <= StSkip;
          end
        end
        StSkip: begin
          if (skip_zero) begin
            remain_q <= remain_q - 1'b1;
          end else begin
            state_q <= neg_q ? StSign : StEmit;
          end
        end
        StSign: begin
          if (out_free) begin
            out_char_q  <= idta_pkg::ChMinus;
            out_final_q <= 1'b0;
            state_q     <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_char_q  <= idta_pkg::ChZero + {2'b00, top_digit};
            out_final_q <= (remain_q == RemOne);
            remain_q    <= remain_q - 1'b1;
            if (remain_q == RemOne) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
